/* rtl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and fixed widths shared by the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int LEN_W   = 6;
    localparam int BITS_W  = 32;
    localparam int ENTRY_W = LEN_W + BITS_W;
    localparam int BYTE_W  = 8;
    localparam int PEND_W  = 7;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = PEND_W + BITS_W;
    localparam int SYM_W   = 8;
    localparam int IN_DATA_W = 48;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_ERR,
        ST_FLUSH
    } t_state;

endpackage

/* rtl/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven Huffman encoder back end: code table load, bit packing, flush.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser carries the request kind (load, encode,
// flush), tdata carries symbol, code length and code bits. Output stream
// (m_axis): tdata is a packed byte with the earliest bit in bit 7, tlast
// marks the byte of a flush, tuser flags a symbol without a code.
// One item is in work at a time; tready is high only while idle.
// Load: writes one entry of the code table RAM.
// Encode: accept, table RAM read, then the serial byte emitter sends one
// completed byte per step (0 to 4) and last stores the pending bits.
// Symbol without a code: one error result.
// Flush: one last byte when bits are pending, no output otherwise.
// Reset clears the pending bits and all table valid bits at once, so every
// entry counts as having no code until loaded; no clearing pass is needed.
// A receiver stall holds the output register and the emitter waits on it;
// no result is dropped.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN  = 32,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // symbol [7:0], code_len [13:8], code_bits [45:14], zero [47:46]
    input  logic [hcbp_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_byte [7:0]
    output logic [hcbp_pkg::BYTE_W-1:0]    o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    // status [0]
    output logic                           o_m_axis_tuser
);

    import hcbp_pkg::*;

    localparam int IDX_W   = $clog2(ALPHABET_SIZE);
    localparam int LEN_LIM = (MAX_CODE_LEN < BITS_W) ? MAX_CODE_LEN : BITS_W;

    t_state                r_state, n_state;
    logic [PEND_W-1:0]     r_pend, n_pend;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [LEN_W-1:0]      r_total, n_total;
    logic                  r_oob, n_oob;
    logic                  r_vld, n_vld;
    logic [ALPHABET_SIZE-1:0] r_valid, n_valid;
    logic                  r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]     r_out_byte, n_out_byte;
    logic                  r_out_last, n_out_last;
    logic                  r_out_status, n_out_status;

    logic                  w_accept;
    logic                  w_out_free;
    t_req                  w_req;
    logic [SYM_W-1:0]      w_sym;
    logic [LEN_W-1:0]      w_len;
    logic [BITS_W-1:0]     w_bits;
    logic [IDX_W-1:0]      w_idx;
    logic                  w_in_range;
    logic [LEN_W-1:0]      w_len_cl;
    logic [63:0]           w_mask;
    logic                  w_we;
    logic [ENTRY_W-1:0]    w_wdata;
    logic [ENTRY_W-1:0]    w_rdata;
    logic [LEN_W-1:0]      w_rd_len;
    logic [BITS_W-1:0]     w_rd_bits;
    logic [BYTE_W-1:0]     w_pad_mask;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_req      = t_req'(i_s_axis_tuser);
    assign w_sym      = i_s_axis_tdata[7:0];
    assign w_len      = i_s_axis_tdata[13:8];
    assign w_bits     = i_s_axis_tdata[45:14];
    assign w_idx      = w_sym[IDX_W-1:0];
    assign w_in_range = {1'b0, w_sym} < 9'(ALPHABET_SIZE);
    assign w_len_cl   = (w_len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : w_len;
    assign w_mask     = (64'd1 << w_len_cl) - 64'd1;
    assign w_we       = w_accept && (w_req == REQ_LOAD) && w_in_range;
    assign w_wdata    = {w_bits & w_mask[BITS_W-1:0], w_len_cl};
    assign w_rd_len   = w_rdata[LEN_W-1:0];
    assign w_rd_bits  = w_rdata[ENTRY_W-1:LEN_W];
    assign w_pad_mask = (8'd1 << r_total[2:0]) - 8'd1;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_total      = r_total;
        n_oob        = r_oob;
        n_vld        = r_vld;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_req)
                        REQ_LOAD: begin
                            if (w_in_range) begin
                                n_valid[w_idx] = 1'b1;
                            end
                        end
                        REQ_ENCODE: begin
                            n_oob   = !w_in_range;
                            n_vld   = r_valid[w_idx];
                            n_state = ST_READ;
                        end
                        REQ_FLUSH: begin
                            if (r_cnt != '0) begin
                                n_state = ST_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_oob || !r_vld || (w_rd_len == '0)) begin
                    n_state = ST_ERR;
                end else begin
                    n_acc   = (ACC_W'(r_pend) << w_rd_len) | ACC_W'(w_rd_bits);
                    n_total = LEN_W'(r_cnt) + w_rd_len;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_total >= LEN_W'(BYTE_W)) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_byte   = BYTE_W'(r_acc >> (r_total - LEN_W'(BYTE_W)));
                        n_out_last   = 1'b0;
                        n_out_status = 1'b0;
                        n_total      = r_total - LEN_W'(BYTE_W);
                    end
                end else begin
                    n_pend  = r_acc[PEND_W-1:0] & w_pad_mask[PEND_W-1:0];
                    n_cnt   = r_total[CNT_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_out_last   = 1'b0;
                    n_out_status = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = {1'b0, r_pend} << (CNT_W'(0) - r_cnt);
                    n_out_last   = 1'b1;
                    n_out_status = 1'b0;
                    n_pend       = '0;
                    n_cnt        = '0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_total      <= n_total;
        r_oob        <= n_oob;
        r_vld        <= n_vld;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

endmodule
